FILE: src/msort_pkg.sv
package msort_pkg;

    localparam int MS_CAPACITY = 64;
    localparam int MS_DATA_W   = 32;

    typedef struct packed {
        logic                        valid;
        logic signed [MS_DATA_W-1:0] value;
    } t_link;

    typedef struct packed {
        logic                        en;
        logic signed [MS_DATA_W-1:0] value;
    } t_ins;

endpackage

FILE: src/msort_cell.sv
module msort_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  msort_pkg::t_ins  i_ins,
    input  logic            i_shift,
    input  msort_pkg::t_link i_left,
    input  logic            i_left_bump,
    input  msort_pkg::t_link i_right,
    output msort_pkg::t_link o_cell,
    output logic            o_bump
);
    import msort_pkg::*;

    logic                        r_valid;
    logic                        n_valid;
    logic signed [MS_DATA_W-1:0] r_value;
    logic signed [MS_DATA_W-1:0] n_value;

    // strict compare keeps equal values in arrival order
    assign o_bump = !r_valid || (r_value > i_ins.value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_shift) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ins.en) begin
            if (i_left_bump) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else if (o_bump) begin
                n_valid = 1'b1;
                n_value = i_ins.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.value = r_value;

endmodule

FILE: src/merge_sorter.sv
// Stable ascending sorter for batches of signed 32-bit values.
// Input stream: one value per transaction in tdata, tlast on the final
// value of a batch. Values are kept in a row of CAPACITY cells, each
// holding one value in sorted position; a new value is placed behind
// every stored value that is less than or equal to it.
// Loading accepts a new value on every transfer. Once full, further values are
// dropped and every result of that batch carries tuser (overflow) = 1.
// The transaction carrying tlast starts the output run: the first result
// is valid on the next cycle and the row shifts one cell toward the
// output per accepted result. tlast marks the final result. The input
// is not ready while a run is being emitted.
// A stalled receiver simply holds the row; nothing is lost.
// Reset empties the row and clears the overflow flag; no clearing pass.
module merge_sorter #(
    parameter int CAPACITY = msort_pkg::MS_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [msort_pkg::MS_DATA_W-1:0]   i_s_axis_tdata,  // [31:0] value
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [msort_pkg::MS_DATA_W-1:0]   o_m_axis_tdata,  // [31:0] sorted_value
    output logic                              o_m_axis_tlast,
    output logic                              o_m_axis_tuser   // [0] overflow
);
    import msort_pkg::*;

    logic  r_emit;
    logic  n_emit;
    logic  r_dropped;
    logic  n_dropped;
    logic  in_fire;
    logic  out_fire;
    logic  full;
    t_ins  ins;
    t_link cells [CAPACITY];
    logic  bumps [CAPACITY];

    assign o_s_axis_tready = !r_emit;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign full     = cells[CAPACITY-1].valid;

    assign ins.en    = in_fire && !full;
    assign ins.value = $signed(i_s_axis_tdata);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link left;
        t_link right;
        logic  left_bump;

        if (g == 0) begin : g_first
            assign left      = '0;
            assign left_bump = 1'b0;
        end else begin : g_mid
            assign left      = cells[g-1];
            assign left_bump = bumps[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign right = '0;
        end else begin : g_inner
            assign right = cells[g+1];
        end

        msort_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ins       (ins),
            .i_shift     (out_fire),
            .i_left      (left),
            .i_left_bump (left_bump),
            .i_right     (right),
            .o_cell      (cells[g]),
            .o_bump      (bumps[g])
        );
    end

    always_comb begin
        n_emit    = r_emit;
        n_dropped = r_dropped;
        if (in_fire && full) begin
            n_dropped = 1'b1;
        end
        if (in_fire && i_s_axis_tlast) begin
            n_emit = 1'b1;
        end
        if (out_fire && o_m_axis_tlast) begin
            n_emit    = 1'b0;
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit    <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_emit    <= n_emit;
            r_dropped <= n_dropped;
        end
    end

    assign o_m_axis_tvalid = r_emit && cells[0].valid;
    assign o_m_axis_tdata  = cells[0].value;
    assign o_m_axis_tlast  = !cells[1].valid;
    assign o_m_axis_tuser  = r_dropped;

    a_sorted_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && ($signed(o_m_axis_tdata) >= $past($signed(o_m_axis_tdata)))))
        else $error("output run not ascending");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("run did not start after final input");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_m_axis_tlast) |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("row not drained at end of run");

    a_flag_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_m_axis_tlast) |=> (o_m_axis_tuser == $past(o_m_axis_tuser)))
        else $error("overflow flag changed within a run");

endmodule
